[rtl/lbf_pkg.sv]
// Package for the largest-box follow controller.
// Shared types and constants: configuration set, queue entry, register indexes.
// No dependencies.
`default_nettype none

package lbf_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * DIFF_BITS;
    localparam int THR_BITS   = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [2:0] {
        REG_AREA_THRESHOLD = 3'd0,
        REG_TARGET_CLASS   = 3'd1,
        REG_IMAGE_WIDTH    = 3'd2,
        REG_ANG_LIMIT      = 3'd3,
        REG_LIN_LIMIT      = 3'd4,
        REG_HOLD_MM        = 3'd5,
        REG_VALID_MIN      = 3'd6,
        REG_VALID_MAX      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [THR_BITS-1:0]   area_threshold;
        logic [7:0]            target_class;
        logic [11:0]           image_width;
        logic [14:0]           ang_limit;
        logic [14:0]           lin_limit;
        logic [15:0]           hold_mm;
        logic [15:0]           valid_min;
        logic [15:0]           valid_max;
    } cfg_t;

    typedef struct packed {
        logic                         qual;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
        logic [COORD_BITS-1:0]        left;
        logic [COORD_BITS-1:0]        right;
        logic [15:0]                  tgt_mm;
        logic                         last;
    } entry_t;

endpackage

`default_nettype wire

[rtl/lbf_front.sv]
// Front end: accepts input words, classifies boxes and forms queue entries.
// Depends on lbf_pkg.
`default_nettype none

module lbf_front
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [71:0]          s_tdata,   // left_x, top_y, right_x, bottom_y,
                                                 // class_id, target_distance
    input  wire logic                 s_tuser,   // box_valid
    input  wire logic                 s_tlast,   // frame_last
    input  wire logic [7:0]           target_class,
    input  wire logic                 fifo_full,
    output logic                      fifo_wr,
    output lbf_pkg::entry_t           fifo_wdata
);

    logic [lbf_pkg::COORD_BITS-1:0] left_x;
    logic [lbf_pkg::COORD_BITS-1:0] top_y;
    logic [lbf_pkg::COORD_BITS-1:0] right_x;
    logic [lbf_pkg::COORD_BITS-1:0] bottom_y;
    logic [7:0]                     class_id;

    assign left_x   = s_tdata[11:0];
    assign top_y    = s_tdata[23:12];
    assign right_x  = s_tdata[35:24];
    assign bottom_y = s_tdata[47:36];
    assign class_id = s_tdata[55:48];

    assign s_tready = !fifo_full;
    assign fifo_wr  = s_tvalid && !fifo_full;

    always_comb
    begin
        fifo_wdata.qual   = s_tuser && (class_id == target_class);
        fifo_wdata.dx     = $signed({1'b0, right_x}) - $signed({1'b0, left_x});
        fifo_wdata.dy     = $signed({1'b0, bottom_y}) - $signed({1'b0, top_y});
        fifo_wdata.left   = left_x;
        fifo_wdata.right  = right_x;
        fifo_wdata.tgt_mm = s_tdata[71:56];
        fifo_wdata.last   = s_tlast;
    end

endmodule

`default_nettype wire

[rtl/lbf_fifo.sv]
// Short queue between front and back ends.
// Depends on lbf_pkg (entry_t, depth constants).
`default_nettype none

module lbf_fifo
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire lbf_pkg::entry_t  wdata,
    input  wire logic             rd,
    output lbf_pkg::entry_t       rdata,
    output logic                  full,
    output logic                  empty
);

    lbf_pkg::entry_t             mem [lbf_pkg::FIFO_DEPTH];
    logic [lbf_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [lbf_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [lbf_pkg::FIFO_AW:0]   count_reg;
    logic                        do_wr;
    logic                        do_rd;

    assign full  = (count_reg == (lbf_pkg::FIFO_AW+1)'(lbf_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/lbf_back.sv]
// Back end: area multiply, running best-box select, drive command and output register.
// Depends on lbf_pkg (entry_t, cfg_t).
`default_nettype none

module lbf_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lbf_pkg::cfg_t    cfg,
    input  wire logic             fifo_empty,
    input  wire lbf_pkg::entry_t  fifo_rdata,
    output logic                  fifo_rd,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [47:0]           m_tdata,   // centre_x, angular_rate, linear_rate, 4'b0
    output logic                  m_tuser    // target_found
);

    localparam int CB = lbf_pkg::COORD_BITS;
    localparam int AB = lbf_pkg::AREA_BITS;

    logic stall;

    // stage 1: area
    logic                    s1_valid_reg;
    logic                    s1_qual_reg;
    logic signed [AB-1:0]    s1_area_reg;
    logic [CB-1:0]           s1_left_reg;
    logic [CB-1:0]           s1_right_reg;
    logic [15:0]             s1_dist_reg;
    logic                    s1_last_reg;

    // running best
    logic signed [AB-1:0]    best_area_reg;
    logic [CB-1:0]           best_left_reg;
    logic [CB-1:0]           best_right_reg;
    logic                    found_reg;

    // stage 2: frame end record
    logic                    s2_valid_reg;
    logic                    s2_found_reg;
    logic [CB-1:0]           s2_left_reg;
    logic [CB-1:0]           s2_right_reg;
    logic [15:0]             s2_dist_reg;

    // stage 3: raw rates
    logic                    s3_valid_reg;
    logic                    s3_found_reg;
    logic [11:0]             s3_cx_reg;
    logic signed [16:0]      s3_ang_reg;
    logic signed [16:0]      s3_lin_reg;

    // output word
    logic                    out_valid_reg;
    logic                    out_found_reg;
    logic [11:0]             out_cx_reg;
    logic [15:0]             out_ang_reg;
    logic [15:0]             out_lin_reg;

    logic signed [AB-1:0]    bar;
    logic                    hit;
    logic [CB-1:0]           left_new;
    logic [CB-1:0]           right_new;

    logic [CB:0]             cx_sum;
    logic [11:0]             cx;
    logic signed [12:0]      ang_diff;
    logic signed [16:0]      ang_ext;
    logic signed [16:0]      ang_raw;
    logic signed [16:0]      lin_diff;
    logic signed [16:0]      lin_half;
    logic                    in_win;

    logic signed [16:0]      ang_lim;
    logic signed [16:0]      lin_lim;
    logic signed [16:0]      ang_clamp;
    logic signed [16:0]      lin_clamp;

    assign stall   = out_valid_reg && !m_tready;
    assign fifo_rd = !fifo_empty && !stall;

    assign bar = found_reg ? best_area_reg
                           : $signed({{(AB-lbf_pkg::THR_BITS){1'b0}}, cfg.area_threshold});
    assign hit       = s1_valid_reg && s1_qual_reg && (s1_area_reg > bar);
    assign left_new  = hit ? s1_left_reg : best_left_reg;
    assign right_new = hit ? s1_right_reg : best_right_reg;

    always_comb
    begin
        cx_sum   = {1'b0, s2_left_reg} + {1'b0, s2_right_reg};
        cx       = cx_sum[CB:1];
        ang_diff = $signed({2'b00, cfg.image_width[11:1]}) - $signed({1'b0, cx});
        ang_ext  = {{4{ang_diff[12]}}, ang_diff};
        ang_raw  = (ang_ext <<< 3) + (ang_ext <<< 1);
        in_win   = (s2_dist_reg >= cfg.valid_min) && (s2_dist_reg <= cfg.valid_max);
        lin_diff = $signed({1'b0, s2_dist_reg}) - $signed({1'b0, cfg.hold_mm});
        lin_half = (lin_diff + $signed({16'b0, lin_diff[16]})) >>> 1;
    end

    always_comb
    begin
        ang_lim = $signed({2'b00, cfg.ang_limit});
        lin_lim = $signed({2'b00, cfg.lin_limit});
        priority if (s3_ang_reg > ang_lim)
        begin
            ang_clamp = ang_lim;
        end
        else if (s3_ang_reg < -ang_lim)
        begin
            ang_clamp = -ang_lim;
        end
        else
        begin
            ang_clamp = s3_ang_reg;
        end
        priority if (s3_lin_reg > lin_lim)
        begin
            lin_clamp = lin_lim;
        end
        else if (s3_lin_reg < -lin_lim)
        begin
            lin_clamp = -lin_lim;
        end
        else
        begin
            lin_clamp = s3_lin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg  <= fifo_rd;
            s2_valid_reg  <= s1_valid_reg && s1_last_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    found_reg <= 1'b0;
                end
                else if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_qual_reg  <= fifo_rdata.qual;
            s1_area_reg  <= fifo_rdata.dx * fifo_rdata.dy;
            s1_left_reg  <= fifo_rdata.left;
            s1_right_reg <= fifo_rdata.right;
            s1_dist_reg  <= fifo_rdata.tgt_mm;
            s1_last_reg  <= fifo_rdata.last;

            if (hit)
            begin
                best_area_reg  <= s1_area_reg;
                best_left_reg  <= s1_left_reg;
                best_right_reg <= s1_right_reg;
            end

            s2_found_reg <= found_reg || hit;
            s2_left_reg  <= left_new;
            s2_right_reg <= right_new;
            s2_dist_reg  <= s1_dist_reg;

            s3_found_reg <= s2_found_reg;
            s3_cx_reg    <= cx;
            s3_ang_reg   <= ang_raw;
            s3_lin_reg   <= in_win ? lin_half : '0;

            out_found_reg <= s3_found_reg;
            out_cx_reg    <= s3_found_reg ? s3_cx_reg : '0;
            out_ang_reg   <= s3_found_reg ? ang_clamp[15:0] : '0;
            out_lin_reg   <= s3_found_reg ? lin_clamp[15:0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {4'b0000, out_lin_reg, out_ang_reg, out_cx_reg};

endmodule

`default_nettype wire

[rtl/largest_box_follow_controller_top.sv]
// Largest-box follow controller, top level: configuration registers and the
// front end, queue and back end. Depends on lbf_pkg, lbf_front, lbf_fifo, lbf_back.
//
// Usage:
//   Input stream (s_*): one detection box per word; s_tlast closes a frame,
//   s_tuser says whether the word carries a box. One word is taken per cycle while s_tready is high.
//   Output stream (m_*): one drive command per frame, sent after the frame's
//   last word; m_tuser flags that a box of the target class was chosen.
//   Config port: cfg_we with cfg_index / cfg_wdata writes one register per
//   cycle; write only while no frame is in flight.
// Timing:
//   Throughput is one input word per clock while s_tready is high; the running best-box
//   compare is combinational, and a hit updates the best-box registers. A frame's command
//   passes from the queue through the area multiply, compare, rate arithmetic, and clamp
//   and output register stages, each one register stage, before it is valid on m_tdata.
// Reset clears the queue, pipeline and running best and loads default register values.
// When a command waits and the receiver holds m_tready low, the whole back end
// freezes; the four-entry queue fills and then s_tready drops.
`default_nettype none

module largest_box_follow_controller_top
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // left_x, top_y, right_x, bottom_y,
                                         // class_id, target_distance
    input  wire logic         s_tuser,   // box_valid
    input  wire logic         s_tlast,   // frame_last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,   // centre_x, angular_rate, linear_rate, zero pad
    output logic              m_tuser,   // target_found
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_wdata
);

    lbf_pkg::cfg_t   cfg_reg;
    lbf_pkg::entry_t fifo_wdata;
    lbf_pkg::entry_t fifo_rdata;
    logic            fifo_wr;
    logic            fifo_rd;
    logic            fifo_full;
    logic            fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.area_threshold <= 24'd20;
            cfg_reg.target_class   <= 8'd0;
            cfg_reg.image_width    <= 12'd640;
            cfg_reg.ang_limit      <= 15'd1500;
            cfg_reg.lin_limit      <= 15'd100;
            cfg_reg.hold_mm        <= 16'd300;
            cfg_reg.valid_min      <= 16'd50;
            cfg_reg.valid_max      <= 16'd5000;
        end
        else if (cfg_we)
        begin
            unique case (lbf_pkg::reg_idx_t'(cfg_index))
                lbf_pkg::REG_AREA_THRESHOLD: cfg_reg.area_threshold <= cfg_wdata;
                lbf_pkg::REG_TARGET_CLASS:   cfg_reg.target_class   <= cfg_wdata[7:0];
                lbf_pkg::REG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_wdata[11:0];
                lbf_pkg::REG_ANG_LIMIT:      cfg_reg.ang_limit      <= cfg_wdata[14:0];
                lbf_pkg::REG_LIN_LIMIT:      cfg_reg.lin_limit      <= cfg_wdata[14:0];
                lbf_pkg::REG_HOLD_MM:        cfg_reg.hold_mm        <= cfg_wdata[15:0];
                lbf_pkg::REG_VALID_MIN:      cfg_reg.valid_min      <= cfg_wdata[15:0];
                lbf_pkg::REG_VALID_MAX:      cfg_reg.valid_max      <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    lbf_front u_front
    (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .target_class (cfg_reg.target_class),
        .fifo_full    (fifo_full),
        .fifo_wr      (fifo_wr),
        .fifo_wdata   (fifo_wdata)
    );

    lbf_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fifo_wr),
        .wdata (fifo_wdata),
        .rd    (fifo_rd),
        .rdata (fifo_rdata),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    lbf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .fifo_rdata (fifo_rdata),
        .fifo_rd    (fifo_rd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
